### rtl/luhn_pkg.sv
// ----------------------------------------------------------------------------
// Luhn card check package
// Shared widths, result codes, controller/datapath structs and the helper
// functions for the binary-to-BCD conversion and the Luhn digit terms.
// ----------------------------------------------------------------------------
package luhn_pkg;

    localparam int CARD_W        = 63;
    localparam int BITS_PER_STEP = 4;
    localparam int BIN_W         = ((CARD_W + BITS_PER_STEP - 1) / BITS_PER_STEP)
                                   * BITS_PER_STEP;
    localparam int CONV_STEPS    = BIN_W / BITS_PER_STEP;
    localparam int NUM_DIGITS    = 19;
    localparam int BCD_W         = 4 * NUM_DIGITS;
    localparam int STEP_W        = 5;
    localparam int COUNT_W       = 5;
    localparam int BRAND_W       = 2;

    localparam logic [BRAND_W-1:0] BRAND_INVALID = 2'd0;
    localparam logic [BRAND_W-1:0] BRAND_AMEX    = 2'd1;
    localparam logic [BRAND_W-1:0] BRAND_VISA    = 2'd2;
    localparam logic [BRAND_W-1:0] BRAND_MASTER  = 2'd3;

    localparam logic [COUNT_W-1:0] LEN_AMEX     = 5'd15;
    localparam logic [COUNT_W-1:0] LEN_VISA_SHT = 5'd13;
    localparam logic [COUNT_W-1:0] LEN_16       = 5'd16;
    localparam logic [COUNT_W-1:0] LEN_MAX      = 5'd19;

    localparam logic [3:0] LEAD_AMEX   = 4'd3;
    localparam logic [3:0] NEXT_AMEX_A = 4'd4;
    localparam logic [3:0] NEXT_AMEX_B = 4'd7;
    localparam logic [3:0] LEAD_VISA   = 4'd4;
    localparam logic [3:0] LEAD_MASTER = 4'd5;
    localparam logic [3:0] NEXT_MC_LO  = 4'd1;
    localparam logic [3:0] NEXT_MC_HI  = 4'd5;

    localparam logic [STEP_W-1:0] CONV_LAST = STEP_W'(CONV_STEPS - 1);
    localparam logic [STEP_W-1:0] WALK_LAST = STEP_W'(NUM_DIGITS - 1);

    typedef struct packed {
        logic load;
        logic conv;
        logic walk;
        logic retire;
    } t_cmd;

    typedef struct packed {
        logic conv_last;
        logic walk_last;
    } t_sts;

    // One double-dabble step: correct every digit of 5 or more, then shift
    // the next binary bit in at the bottom.
    function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd,
                                                input logic b);
        logic [BCD_W-1:0] adj;
        int i;
        adj = bcd;
        for (i = 0; i < NUM_DIGITS; i++) begin
            if (adj[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], b};
    endfunction

    // Contribution of one digit; a doubled digit of 10 or more adds its
    // two decimal digits.
    function automatic logic [3:0] luhn_term(input logic [3:0] d, input logic dbl);
        logic [4:0] twice;
        twice = {d, 1'b0};
        if (!dbl) begin
            return d;
        end else if (twice >= 5'd10) begin
            return 4'(twice - 5'd9);
        end else begin
            return twice[3:0];
        end
    endfunction

endpackage

### rtl/luhn_ctrl.sv
// ----------------------------------------------------------------------------
// Luhn check controller
// Sequences input capture, BCD conversion, digit walk and result hand-off,
// and owns the output valid flag.
// ----------------------------------------------------------------------------
module luhn_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    input  luhn_pkg::t_sts  i_sts,
    output luhn_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_WALK,
        S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid & i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.conv = 1'b1;
                if (i_sts.conv_last) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_sts.walk_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // The result register frees up in the same cycle its beat leaves.
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.retire = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### rtl/luhn_dp.sv
// ----------------------------------------------------------------------------
// Luhn check datapath
// Converts the card number to BCD four bits per cycle, then walks the
// digits from the least significant end to build the count, the two
// leading digits and the Luhn sum mod 10, and finally classifies the card.
// ----------------------------------------------------------------------------
module luhn_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  luhn_pkg::t_cmd                    i_cmd,
    output luhn_pkg::t_sts                    o_sts,
    input  logic [luhn_pkg::CARD_W-1:0]       i_card_number,
    output logic [luhn_pkg::BRAND_W-1:0]      o_brand,
    output logic                              o_checksum_ok,
    output logic [luhn_pkg::COUNT_W-1:0]      o_digit_total
);

    logic [luhn_pkg::STEP_W-1:0]  r_step, n_step;
    logic [luhn_pkg::BIN_W-1:0]   r_bin;
    logic [luhn_pkg::BCD_W-1:0]   r_bcd, n_bcd_conv;
    logic [3:0]                   r_mod, n_mod;
    logic [luhn_pkg::COUNT_W-1:0] r_count;
    logic [3:0]                   r_lead, r_next, r_prev;
    logic [3:0]                   w_digit, w_term;
    logic [4:0]                   w_mod_sum;
    logic                         w_ok;
    logic [luhn_pkg::BRAND_W-1:0] w_brand;
    logic [luhn_pkg::BRAND_W-1:0] r_brand;
    logic                         r_ok;
    logic [luhn_pkg::COUNT_W-1:0] r_total;

    assign o_sts.conv_last = (r_step == luhn_pkg::CONV_LAST);
    assign o_sts.walk_last = (r_step == luhn_pkg::WALK_LAST);

    always_comb begin
        n_bcd_conv = r_bcd;
        for (int k = 0; k < luhn_pkg::BITS_PER_STEP; k++) begin
            n_bcd_conv = luhn_pkg::dabble(n_bcd_conv, r_bin[luhn_pkg::BIN_W-1-k]);
        end
    end

    always_comb begin
        n_step = r_step;
        if (i_cmd.load) begin
            n_step = '0;
        end else if (i_cmd.conv) begin
            n_step = o_sts.conv_last ? '0 : r_step + 5'd1;
        end else if (i_cmd.walk) begin
            n_step = r_step + 5'd1;
        end
    end

    // Digit at an odd index from zero is the 2nd, 4th, ... from the right.
    assign w_digit   = r_bcd[3:0];
    assign w_term    = luhn_pkg::luhn_term(w_digit, r_step[0]);
    assign w_mod_sum = {1'b0, r_mod} + {1'b0, w_term};
    assign n_mod     = (w_mod_sum >= 5'd10) ? 4'(w_mod_sum - 5'd10) : w_mod_sum[3:0];

    assign w_ok = (r_mod == 4'd0);

    always_comb begin
        w_brand = luhn_pkg::BRAND_INVALID;
        if (w_ok) begin
            if (r_count == luhn_pkg::LEN_AMEX && r_lead == luhn_pkg::LEAD_AMEX &&
                (r_next == luhn_pkg::NEXT_AMEX_A || r_next == luhn_pkg::NEXT_AMEX_B)) begin
                w_brand = luhn_pkg::BRAND_AMEX;
            end else if (r_lead == luhn_pkg::LEAD_VISA &&
                         (r_count == luhn_pkg::LEN_VISA_SHT ||
                          r_count == luhn_pkg::LEN_16)) begin
                w_brand = luhn_pkg::BRAND_VISA;
            end else if (r_count == luhn_pkg::LEN_16 &&
                         r_lead == luhn_pkg::LEAD_MASTER &&
                         r_next >= luhn_pkg::NEXT_MC_LO &&
                         r_next <= luhn_pkg::NEXT_MC_HI) begin
                w_brand = luhn_pkg::BRAND_MASTER;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin   <= {{(luhn_pkg::BIN_W - luhn_pkg::CARD_W){1'b0}}, i_card_number};
            r_bcd   <= '0;
            r_mod   <= '0;
            r_count <= '0;
            r_lead  <= '0;
            r_next  <= '0;
            r_prev  <= '0;
        end else if (i_cmd.conv) begin
            r_bin <= {r_bin[luhn_pkg::BIN_W-luhn_pkg::BITS_PER_STEP-1:0],
                      {luhn_pkg::BITS_PER_STEP{1'b0}}};
            r_bcd <= n_bcd_conv;
        end else if (i_cmd.walk) begin
            r_bcd  <= {4'd0, r_bcd[luhn_pkg::BCD_W-1:4]};
            r_mod  <= n_mod;
            r_prev <= w_digit;
            // The highest nonzero digit seen so far sets the length and prefix.
            if (w_digit != 4'd0) begin
                r_count <= r_step + 5'd1;
                r_lead  <= w_digit;
                r_next  <= r_prev;
            end
        end
        if (i_cmd.retire) begin
            r_brand <= w_brand;
            r_ok    <= w_ok;
            r_total <= r_count;
        end
    end

    assign o_brand       = r_brand;
    assign o_checksum_ok = r_ok;
    assign o_digit_total = r_total;

endmodule

### rtl/luhn_card_brand_check.sv
// ----------------------------------------------------------------------------
// Luhn card brand check, top level
// Input channel: one card number per beat (i_in_valid / o_in_stall).
// Output channel: brand, Luhn checksum flag and digit count per beat
// (o_out_valid / i_out_stall).
// An accepted number is converted to BCD four bits of the binary value per
// cycle through a chain of shift-add-3 steps, one per bit, its 19 digit
// slots are then walked one per cycle, and the card is classified into the
// output register once that register is free. A new number is taken only
// after the result of the last one has gone into the output register.
// o_in_stall is high while a number is in work. The next number is taken
// while a finished result still waits; a result held by i_out_stall keeps
// its payload and only blocks the block once the next result is ready.
// Synchronous reset clears the controller and drops o_out_valid.
// ----------------------------------------------------------------------------
module luhn_card_brand_check (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [luhn_pkg::CARD_W-1:0]   i_card_number,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [luhn_pkg::BRAND_W-1:0]  o_brand,
    output logic                          o_checksum_ok,
    output logic [luhn_pkg::COUNT_W-1:0]  o_digit_total
);

    luhn_pkg::t_cmd w_cmd;
    luhn_pkg::t_sts w_sts;

    luhn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    luhn_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_card_number (i_card_number),
        .o_brand       (o_brand),
        .o_checksum_ok (o_checksum_ok),
        .o_digit_total (o_digit_total)
    );

endmodule

### rtl/luhn_chk.sv
// ----------------------------------------------------------------------------
// Luhn card brand check, port checker
// Watches the top-level ports for reset behavior, output hold, the digit
// count range and consistency between brand, checksum flag and digit count.
// ----------------------------------------------------------------------------
module luhn_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [luhn_pkg::BRAND_W-1:0]  o_brand,
    input logic                          o_checksum_ok,
    input logic [luhn_pkg::COUNT_W-1:0]  o_digit_total
);

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid survived reset");

    a_stalled_beat_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_brand) && $stable(o_checksum_ok) &&
            $stable(o_digit_total))
        else $error("stalled result beat changed");

    a_brand_needs_checksum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_brand != luhn_pkg::BRAND_INVALID |-> o_checksum_ok)
        else $error("brand reported without a passing checksum");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_digit_total <= luhn_pkg::LEN_MAX)
        else $error("digit count out of range");

    a_brand_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_brand == luhn_pkg::BRAND_INVALID) ||
            (o_brand == luhn_pkg::BRAND_AMEX && o_digit_total == luhn_pkg::LEN_AMEX) ||
            (o_brand == luhn_pkg::BRAND_VISA &&
             (o_digit_total == luhn_pkg::LEN_VISA_SHT ||
              o_digit_total == luhn_pkg::LEN_16)) ||
            (o_brand == luhn_pkg::BRAND_MASTER && o_digit_total == luhn_pkg::LEN_16))
        else $error("brand does not match digit count");

endmodule

bind luhn_card_brand_check luhn_chk u_luhn_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_brand       (o_brand),
    .o_checksum_ok (o_checksum_ok),
    .o_digit_total (o_digit_total)
);
